FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge while reset is released.
`define NPA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define NPA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`else

`define NPA_ASSERT(lbl, clk, rst_n, prop)
`define NPA_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: rtl/npa_pkg.sv
`default_nettype none

package npa_pkg;

  // Automaton size
  localparam int STATE_CNT   = 16;
  localparam int SYMBOL_BITS = 8;
  localparam int SYM_COUNT   = 1 << SYMBOL_BITS;
  localparam int STATE_IDX_W = (STATE_CNT > 1) ? $clog2(STATE_CNT) : 1;
  // One table row holds the next-state masks of all states for one symbol
  localparam int ROW_W       = STATE_CNT * STATE_CNT;

  // Port field widths
  localparam int MODE_W   = 2;
  localparam int SYMBOL_W = 8;
  localparam int FROM_W   = 4;
  localparam int MASK_W   = 16;
  localparam int ACTIVE_W = 16;
  localparam int FINAL_W  = 16;

  // Configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_FINAL_MASK = '0;

  // Queues
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
  localparam int RESQ_LVL_W = $clog2(RESQ_DEPTH + 1);

  localparam logic [STATE_CNT-1:0] START_SET = STATE_CNT'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_SYMBOL  = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e                  op;
    logic [SYMBOL_BITS-1:0] sym;
    logic [STATE_IDX_W-1:0] from;
    logic [STATE_CNT-1:0]   mask;
  } cmd_t;

  typedef struct packed {
    logic                accepted;
    logic [ACTIVE_W-1:0] active_set;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/npa_ram.sv
`default_nettype none

module npa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/npa_front.sv
`default_nettype none

module npa_front import npa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [SYMBOL_W-1:0] symbol_i,
  input  logic [FROM_W-1:0]   from_state_i,
  input  logic [MASK_W-1:0]   next_mask_i,
  output logic                full_o,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o,
  input  logic                cmd_pop_i
);

  cmd_t                  cmd_in;
  logic                  keep;
  logic                  enq;
  logic                  deq;
  cmd_t                  mem_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;

  // Classify the request; drop unused modes and loads from a missing state.
  always_comb begin
    cmd_in      = '0;
    cmd_in.sym  = SYMBOL_BITS'(symbol_i);
    cmd_in.from = STATE_IDX_W'(from_state_i);
    cmd_in.mask = STATE_CNT'(next_mask_i);
    keep        = 1'b0;
    unique case (mode_i)
      MODE_LOAD: begin
        cmd_in.op = MODE_LOAD;
        keep      = (32'(from_state_i) < STATE_CNT);
      end
      MODE_SYMBOL: begin
        cmd_in.op = MODE_SYMBOL;
        keep      = 1'b1;
      end
      MODE_RESTART: begin
        cmd_in.op = MODE_RESTART;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full_o      = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign enq         = push_i && !full_o && keep;
  assign deq         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = enq ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = deq ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq && !deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (deq && !enq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/npa_back.sv
`default_nettype none
`include "assert_macros.svh"

module npa_back import npa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_pop_o,
  input  logic [FINAL_W-1:0]    final_mask_i,
  input  logic [RESQ_LVL_W-1:0] resq_level_i,
  output logic                  res_push_o,
  output res_t                  res_o
);

  logic                   issue;
  logic                   e_valid_q;
  cmd_t                   e_cmd_q;
  logic                   e_sym;
  logic                   e_restart;
  logic [SYM_COUNT-1:0]   valid_q, valid_d;
  logic                   fwd_valid_q;
  logic [SYMBOL_BITS-1:0] fwd_sym_q;
  logic [ROW_W-1:0]       fwd_row_q;
  logic [ROW_W-1:0]       rd_row;
  logic [ROW_W-1:0]       row_cur;
  logic [ROW_W-1:0]       row_new;
  logic                   wr_en;
  logic [STATE_CNT-1:0]   next_set;
  logic [STATE_CNT-1:0]   active_q, active_d;

  assign e_sym     = e_valid_q && (e_cmd_q.op == MODE_SYMBOL);
  assign e_restart = e_valid_q && (e_cmd_q.op == MODE_RESTART);

  // Hold symbols back unless the result queue has room for them.
  assign issue = cmd_valid_i &&
                 ((cmd_i.op != MODE_SYMBOL) ||
                  ((32'(resq_level_i) + 32'(e_sym)) < RESQ_DEPTH));
  assign cmd_pop_o = issue;

  npa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SYM_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (e_cmd_q.sym),
    .wdata_i (row_new),
    .re_i    (issue),
    .raddr_i (cmd_i.sym),
    .rdata_o (rd_row)
  );

  // The RAM misses a write made in the cycle of the read; forward it.
  always_comb begin
    if (fwd_valid_q && (fwd_sym_q == e_cmd_q.sym)) begin
      row_cur = fwd_row_q;
    end else if (valid_q[e_cmd_q.sym]) begin
      row_cur = rd_row;
    end else begin
      row_cur = '0;
    end
  end

  always_comb begin
    row_new  = row_cur;
    next_set = '0;
    for (int s = 0; s < STATE_CNT; s++) begin
      if (STATE_IDX_W'(s) == e_cmd_q.from) begin
        row_new[s*STATE_CNT +: STATE_CNT] = row_cur[s*STATE_CNT +: STATE_CNT] |
                                            e_cmd_q.mask;
      end
      if (active_q[s]) begin
        next_set = next_set | row_cur[s*STATE_CNT +: STATE_CNT];
      end
    end
  end

  assign wr_en = e_valid_q && (e_cmd_q.op == MODE_LOAD);

  always_comb begin
    active_d = active_q;
    valid_d  = valid_q;
    if (e_valid_q) begin
      unique case (e_cmd_q.op)
        MODE_LOAD:    valid_d[e_cmd_q.sym] = 1'b1;
        MODE_SYMBOL:  active_d = next_set;
        MODE_RESTART: active_d = START_SET;
        default:      active_d = active_q;
      endcase
    end
  end

  assign res_push_o       = e_sym;
  assign res_o.accepted   = |(next_set & STATE_CNT'(final_mask_i));
  assign res_o.active_set = ACTIVE_W'(next_set);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
      valid_q     <= '0;
      active_q    <= START_SET;
    end else begin
      e_valid_q   <= issue;
      fwd_valid_q <= wr_en;
      valid_q     <= valid_d;
      active_q    <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      e_cmd_q <= cmd_i;
    end
    if (wr_en) begin
      fwd_sym_q <= e_cmd_q.sym;
      fwd_row_q <= row_new;
    end
  end

  `NPA_ASSERT(a_res_room, clk_i, rst_ni, res_push_o |-> (32'(resq_level_i) < RESQ_DEPTH))
  `NPA_ASSERT(a_exec_after_read, clk_i, rst_ni, e_valid_q |-> $past(issue))
  `NPA_ASSERT(a_restart_start, clk_i, rst_ni, e_restart |=> (active_q == START_SET))

endmodule

`default_nettype wire

FILE: rtl/npa_resq.sv
`default_nettype none
`include "assert_macros.svh"

module npa_resq import npa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  res_t                  res_i,
  input  logic                  pop_i,
  output logic                  empty_o,
  output res_t                  res_o,
  output logic [RESQ_LVL_W-1:0] level_o
);

  res_t                  mem_q [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [RESQ_LVL_W-1:0] level_q, level_d;
  logic                  deq;

  assign empty_o = (level_q == '0);
  assign res_o   = mem_q[rd_ptr_q];
  assign level_o = level_q;
  assign deq     = pop_i && !empty_o;

  always_comb begin
    level_d = level_q;
    if (push_i && !deq) begin
      level_d = level_q + 1'b1;
    end else if (deq && !push_i) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (deq) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  `NPA_ASSERT_ALWAYS(a_level_bound, clk_i, 32'(level_q) <= RESQ_DEPTH)

endmodule

`default_nettype wire

FILE: rtl/nfa_prefix_acceptor.sv
// Channel   Direction  Handshake             Payload
// input     in         push_i / full_o       mode_i symbol_i from_state_i next_mask_i
// result    out        pop_i / empty_o       accepted_o active_set_o
// config    in         psel penable pwrite   paddr pwdata / prdata, pready tied high
//
// Sustains one item per cycle while the result queue has room for symbol results.
// Each symbol reads one table row (all states for that symbol) from the two-port
// table RAM, then ORs and updates the active set in the following cycle.
// Reset clears the per-row valid bits at once; no clearing sweep is needed.
// A four-entry result queue absorbs a stalled reader; the two-entry command queue
// raises full_o when it fills while symbols are held back for lack of result space.
`default_nettype none

module nfa_prefix_acceptor import npa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [SYMBOL_W-1:0] symbol_i,
  input  logic [FROM_W-1:0]   from_state_i,
  input  logic [MASK_W-1:0]   next_mask_i,
  output logic                empty_o,
  input  logic                pop_i,
  output logic                accepted_o,
  output logic [ACTIVE_W-1:0] active_set_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic                  cmd_valid;
  cmd_t                  cmd;
  logic                  cmd_pop;
  logic                  res_push;
  res_t                  res_in;
  res_t                  res_out;
  logic [RESQ_LVL_W-1:0] resq_level;
  logic [FINAL_W-1:0]    final_mask_q, final_mask_d;
  logic                  sel_final;

  assign pready    = 1'b1;
  assign sel_final = (paddr[PADDR_W-1:2] == REG_FINAL_MASK);
  assign prdata    = sel_final ? PDATA_W'(final_mask_q) : '0;

  always_comb begin
    final_mask_d = final_mask_q;
    if (psel && penable && pwrite && pready && sel_final) begin
      final_mask_d = pwdata[FINAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      final_mask_q <= '0;
    end else begin
      final_mask_q <= final_mask_d;
    end
  end

  npa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .mode_i       (mode_i),
    .symbol_i     (symbol_i),
    .from_state_i (from_state_i),
    .next_mask_i  (next_mask_i),
    .full_o       (full_o),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  npa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .final_mask_i (final_mask_q),
    .resq_level_i (resq_level),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  npa_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .pop_i   (pop_i),
    .empty_o (empty_o),
    .res_o   (res_out),
    .level_o (resq_level)
  );

  assign accepted_o   = res_out.accepted;
  assign active_set_o = res_out.active_set;

endmodule

`default_nettype wire
